[rtl/bat_pkg.sv]
`timescale 1ns / 1ps
package bat_pkg;

  typedef enum logic [1:0] {
    ACT_MALLOC = 2'd0,
    ACT_CALLOC = 2'd1,
    ACT_FREE   = 2'd2,
    ACT_STATS  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_SPACE = 3'd1,
    ST_OVERFLOW = 3'd2,
    ST_BAD_FREE = 3'd3,
    ST_NULL     = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  localparam int unsigned CFG_HEAP_BYTES = 0;
  localparam int unsigned CFG_HEAP_BASE  = 1;
  localparam logic [31:0] HEAP_BYTES_RESET = 32'd8388608;
  localparam logic [31:0] HEAP_BASE_RESET  = 32'd65536;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] byte_count;
    logic [31:0] element_count;
    logic [31:0] free_address;
  } in_item_t;

  typedef struct packed {
    logic [31:0] granted_address;
    logic [2:0]  status;
    logic [6:0]  active_count;
    logic [63:0] total_count;
    logic [63:0] fail_count;
    logic [31:0] active_bytes;
    logic [63:0] total_bytes;
    logic [63:0] fail_bytes;
    logic [31:0] lowest_address;
    logic [31:0] highest_address;
  } out_item_t;

  // Token that travels down the cell chain.
  typedef struct packed {
    logic        go;       // token present
    logic        is_free;  // 1: look for address, 0: look for empty slot
    logic        done;     // an earlier cell already took it
    logic [31:0] addr;     // address to match or to store
    logic [31:0] bytes;    // size to store / size found
  } tok_t;

endpackage

[rtl/bat_cell.sv]
`timescale 1ns / 1ps
module bat_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  bat_pkg::tok_t tok_in,
  output bat_pkg::tok_t tok_out
);

  logic        valid_r;
  logic [31:0] addr_r;
  logic [31:0] bytes_r;
  bat_pkg::tok_t tok_r;
  bat_pkg::tok_t tok_nxt;
  logic hit;

  always_comb begin
    hit = tok_in.go && !tok_in.done &&
          (tok_in.is_free ? (valid_r && addr_r == tok_in.addr) : !valid_r);
    tok_nxt = tok_in;
    if (hit) begin
      tok_nxt.done = 1'b1;
      if (tok_in.is_free) tok_nxt.bytes = bytes_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      tok_r.go <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
      if (hit) valid_r <= !tok_in.is_free;
    end
    if (hit && !tok_in.is_free) begin
      addr_r  <= tok_in.addr;
      bytes_r <= tok_in.bytes;
    end
  end

  assign tok_out = tok_r;

endmodule

[rtl/bump_allocator_with_tracking.sv]
`timescale 1ns / 1ps
// Channel | Dir | Handshake              | Payload
// in_     | in  | in_valid / in_ready    | bat_pkg::in_item_t
// out_    | out | out_valid / out_ready  | bat_pkg::out_item_t
// cfg_    | in  | cfg_we                 | cfg_index, cfg_data
//
// One transfer at a time. Stats only and null free answer straight from the
// idle state. A zero or oversized malloc fails in the space check; a calloc
// overflow fails after the multiply. Free sends a token down the chain of
// TABLE_DEPTH cells, one cell per cycle. Malloc adds the space check before
// the chain; calloc adds the multiply states S_MUL and S_WAIT before that.
// Reset (rst_n, synchronous) clears all valid bits and statistics at once.
// The result sits in an output register; in_ready rises again once taken.
module bump_allocator_with_tracking #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bat_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bat_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_CHECK, S_CHAIN, S_WAIT
  } state_t;

  state_t state_r;
  bat_pkg::in_item_t req_r;
  logic [31:0] heap_bytes_r, heap_base_r;
  logic [32:0] bump_r;
  logic [6:0]  live_cnt_r;
  logic [31:0] live_bytes_r, low_r, high_r;
  logic [63:0] gtot_r, ftot_r, gbytes_r, fbytes_r;
  logic [63:0] prod_r;
  logic [31:0] size_r;
  bat_pkg::out_item_t out_r;
  logic out_valid_r;

  bat_pkg::tok_t tok_head;
  bat_pkg::tok_t chain [TABLE_DEPTH+1];

  assign chain[0] = tok_head;

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      bat_cell u_cell (.clk(clk), .rst_n(rst_n), .tok_in(chain[g]),
                       .tok_out(chain[g+1]));
    end
  endgenerate

  bat_pkg::tok_t tail;
  assign tail = chain[TABLE_DEPTH];

  logic [31:0] new_addr, last_addr;
  assign new_addr  = heap_base_r + bump_r[31:0];
  assign last_addr = new_addr + size_r - 32'd1;

  logic [33:0] need;
  assign need = {1'b0, bump_r} + {2'b0, size_r};

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    tok_head = '0;
    if (state_r == S_CHECK && !(size_r == 32'd0 ||
        need > {2'b0, heap_bytes_r})) begin
      tok_head.go    = 1'b1;
      tok_head.addr  = new_addr;
      tok_head.bytes = size_r;
    end
    if (state_r == S_IDLE && in_valid && in_ready &&
        in_data.action == bat_pkg::ACT_FREE && in_data.free_address != 32'd0) begin
      tok_head.go      = 1'b1;
      tok_head.is_free = 1'b1;
      tok_head.addr    = in_data.free_address;
    end
  end

  // Compose the result from the statistics that will hold after this step.
  function automatic bat_pkg::out_item_t pack(
    input logic [31:0] ga, input bat_pkg::status_t st, input logic [6:0] lc,
    input logic [63:0] gt, input logic [63:0] ft, input logic [31:0] lb,
    input logic [63:0] gb, input logic [63:0] fb, input logic [31:0] lo,
    input logic [31:0] hi);
    bat_pkg::out_item_t o;
    o.granted_address = ga;
    o.status          = st;
    o.active_count    = lc;
    o.total_count     = gt;
    o.fail_count      = ft;
    o.active_bytes    = lb;
    o.total_bytes     = gb;
    o.fail_bytes      = fb;
    o.lowest_address  = lo;
    o.highest_address = hi;
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      heap_bytes_r <= bat_pkg::HEAP_BYTES_RESET;
      heap_base_r  <= bat_pkg::HEAP_BASE_RESET;
      bump_r       <= '0;
      live_cnt_r   <= '0;
      live_bytes_r <= '0;
      low_r        <= '0;
      high_r       <= '0;
      gtot_r       <= '0;
      ftot_r       <= '0;
      gbytes_r     <= '0;
      fbytes_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == 1'(bat_pkg::CFG_HEAP_BASE)) heap_base_r  <= cfg_data;
        else                                       heap_bytes_r <= cfg_data;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            req_r  <= in_data;
            size_r <= in_data.byte_count;
            unique case (bat_pkg::action_t'(in_data.action))
              bat_pkg::ACT_MALLOC: state_r <= S_CHECK;
              bat_pkg::ACT_CALLOC: state_r <= S_MUL;
              bat_pkg::ACT_FREE: begin
                if (in_data.free_address == 32'd0) begin
                  out_r <= pack('0, bat_pkg::ST_NULL, live_cnt_r, gtot_r, ftot_r,
                                live_bytes_r, gbytes_r, fbytes_r, low_r, high_r);
                  out_valid_r <= 1'b1;
                end else begin
                  state_r <= S_CHAIN;
                end
              end
              default: begin
                out_r <= pack('0, bat_pkg::ST_OK, live_cnt_r, gtot_r, ftot_r,
                              live_bytes_r, gbytes_r, fbytes_r, low_r, high_r);
                out_valid_r <= 1'b1;
              end
            endcase
          end
        end
        S_MUL: begin
          prod_r  <= req_r.element_count * req_r.byte_count;
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          size_r <= prod_r[31:0];
          if (prod_r[63:32] != 32'd0) begin
            ftot_r   <= ftot_r + 64'd1;
            fbytes_r <= fbytes_r + {32'd0, prod_r[31:0]};
            out_r <= pack('0, bat_pkg::ST_OVERFLOW, live_cnt_r, gtot_r,
                          ftot_r + 64'd1, live_bytes_r, gbytes_r,
                          fbytes_r + {32'd0, prod_r[31:0]}, low_r, high_r);
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (tok_head.go) begin
            state_r <= S_CHAIN;
          end else begin
            ftot_r   <= ftot_r + 64'd1;
            fbytes_r <= fbytes_r + {32'd0, size_r};
            out_r <= pack('0, bat_pkg::ST_NO_SPACE, live_cnt_r, gtot_r,
                          ftot_r + 64'd1, live_bytes_r, gbytes_r,
                          fbytes_r + {32'd0, size_r}, low_r, high_r);
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        S_CHAIN: begin
          if (tail.go) begin
            state_r <= S_IDLE;
            out_valid_r <= 1'b1;
            if (tail.is_free) begin
              if (tail.done) begin
                live_cnt_r   <= live_cnt_r - 7'd1;
                live_bytes_r <= live_bytes_r - tail.bytes;
                out_r <= pack('0, bat_pkg::ST_OK, live_cnt_r - 7'd1, gtot_r,
                              ftot_r, live_bytes_r - tail.bytes, gbytes_r,
                              fbytes_r, low_r, high_r);
              end else begin
                out_r <= pack('0, bat_pkg::ST_BAD_FREE, live_cnt_r, gtot_r,
                              ftot_r, live_bytes_r, gbytes_r, fbytes_r,
                              low_r, high_r);
              end
            end else if (tail.done) begin
              bump_r       <= bump_r + {1'b0, size_r};
              live_cnt_r   <= live_cnt_r + 7'd1;
              live_bytes_r <= live_bytes_r + size_r;
              gtot_r       <= gtot_r + 64'd1;
              gbytes_r     <= gbytes_r + {32'd0, size_r};
              if (low_r == 32'd0 || tail.addr < low_r) low_r <= tail.addr;
              if (last_addr > high_r) high_r <= last_addr;
              out_r <= pack(tail.addr, bat_pkg::ST_OK, live_cnt_r + 7'd1,
                            gtot_r + 64'd1, ftot_r, live_bytes_r + size_r,
                            gbytes_r + {32'd0, size_r}, fbytes_r,
                            (low_r == 32'd0 || tail.addr < low_r) ? tail.addr
                                                                  : low_r,
                            (last_addr > high_r) ? last_addr : high_r);
            end else begin
              ftot_r   <= ftot_r + 64'd1;
              fbytes_r <= fbytes_r + {32'd0, size_r};
              out_r <= pack('0, bat_pkg::ST_FULL, live_cnt_r, gtot_r,
                            ftot_r + 64'd1, live_bytes_r, gbytes_r,
                            fbytes_r + {32'd0, size_r}, low_r, high_r);
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_cnt_r <= 7'(TABLE_DEPTH)) else $error("live count above table depth");
  // A grant never takes the offset past the largest possible heap size.
  a_bump_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !bump_r[32]) else $error("bump offset beyond 32-bit range");
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    tok_head.go |=> state_r == S_CHAIN) else $error("token without chain state");
  a_gtot_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && gtot_r != $past(gtot_r) |-> $rose(out_valid_r))
    else $error("grant count moved without a result");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
module testbench;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int RANDOM_ITEMS = 1700;

  // Predicts each allocator result and holds the results still to come.
  class alloc_scoreboard;
    logic [31:0] heap_bytes;
    logic [31:0] heap_base;
    logic [63:0] offset;
    logic [31:0] slot_addr [64];
    logic [31:0] slot_bytes [64];
    bit          slot_live [64];
    logic [6:0]  live_n;
    logic [31:0] live_b;
    logic [63:0] grant_n, fail_n, grant_b, fail_b;
    logic [31:0] low_mark, high_mark;
    bat_pkg::out_item_t pending_results[$];
    int          errors;

    function new();
      heap_bytes = bat_pkg::HEAP_BYTES_RESET;
      heap_base  = bat_pkg::HEAP_BASE_RESET;
      offset = '0;
      foreach (slot_live[i]) slot_live[i] = 0;
      live_n = '0; live_b = '0;
      grant_n = '0; fail_n = '0; grant_b = '0; fail_b = '0;
      low_mark = '0; high_mark = '0;
      errors = 0;
    endfunction

    function void set_reg(int idx, logic [31:0] val);
      if (idx == bat_pkg::CFG_HEAP_BYTES) heap_bytes = val;
      else heap_base = val;
    endfunction

    function void fail(logic [31:0] size);
      fail_n += 64'd1;
      fail_b += 64'(size);
    endfunction

    // Bump allocation; returns the status, address through addr.
    function bat_pkg::status_t grab(logic [31:0] size, output logic [31:0] addr);
      int slot;
      logic [31:0] last;
      addr = '0;
      slot = -1;
      if (size == 0 || offset + 64'(size) > 64'(heap_bytes)) begin
        fail(size);
        return bat_pkg::ST_NO_SPACE;
      end
      for (int i = 0; i < 64; i++)
        if (!slot_live[i] && slot < 0) slot = i;
      if (slot < 0) begin
        fail(size);
        return bat_pkg::ST_FULL;
      end
      addr = heap_base + offset[31:0];
      offset += 64'(size);
      slot_live[slot] = 1;
      slot_addr[slot] = addr;
      slot_bytes[slot] = size;
      live_n += 7'd1;
      live_b += size;
      grant_n += 64'd1;
      grant_b += 64'(size);
      if (low_mark == 0 || addr < low_mark) low_mark = addr;
      last = addr + size - 32'd1;
      if (last > high_mark) high_mark = last;
      return bat_pkg::ST_OK;
    endfunction

    function void note_request(bat_pkg::in_item_t it);
      bat_pkg::out_item_t r;
      logic [63:0]        prod;
      logic [31:0]        addr;
      bat_pkg::status_t   st;
      r = '0;
      addr = '0;
      st = bat_pkg::ST_OK;
      case (bat_pkg::action_t'(it.action))
        bat_pkg::ACT_MALLOC: st = grab(it.byte_count, addr);
        bat_pkg::ACT_CALLOC: begin
          prod = 64'(it.element_count) * 64'(it.byte_count);
          if (it.element_count != 0 && prod[63:32] != 0) begin
            fail(prod[31:0]);
            st = bat_pkg::ST_OVERFLOW;
          end else begin
            st = grab(prod[31:0], addr);
          end
        end
        bat_pkg::ACT_FREE: begin
          if (it.free_address == 0) begin
            st = bat_pkg::ST_NULL;
          end else begin
            st = bat_pkg::ST_BAD_FREE;
            // lowest matching slot wins when addresses repeat
            for (int i = 0; i < 64; i++)
              if (st == bat_pkg::ST_BAD_FREE && slot_live[i] &&
                  slot_addr[i] == it.free_address) begin
                slot_live[i] = 0;
                live_n -= 7'd1;
                live_b -= slot_bytes[i];
                st = bat_pkg::ST_OK;
              end
          end
        end
        default: ;
      endcase
      r.granted_address = addr;
      r.status          = st;
      r.active_count    = live_n;
      r.total_count     = grant_n;
      r.fail_count      = fail_n;
      r.active_bytes    = live_b;
      r.total_bytes     = grant_b;
      r.fail_bytes      = fail_b;
      r.lowest_address  = low_mark;
      r.highest_address = high_mark;
      pending_results.push_back(r);
    endfunction

    function void cmp(string name, logic [63:0] exp_v, logic [63:0] got_v);
      if (got_v !== exp_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_result(bat_pkg::out_item_t got);
      bat_pkg::out_item_t e;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transfer, got %p", $time, got);
        return;
      end
      e = pending_results.pop_front();
      cmp("granted_address", 64'(e.granted_address), 64'(got.granted_address));
      cmp("status", 64'(e.status), 64'(got.status));
      cmp("active_count", 64'(e.active_count), 64'(got.active_count));
      cmp("total_count", e.total_count, got.total_count);
      cmp("fail_count", e.fail_count, got.fail_count);
      cmp("active_bytes", 64'(e.active_bytes), 64'(got.active_bytes));
      cmp("total_bytes", e.total_bytes, got.total_bytes);
      cmp("fail_bytes", e.fail_bytes, got.fail_bytes);
      cmp("lowest_address", 64'(e.lowest_address), 64'(got.lowest_address));
      cmp("highest_address", 64'(e.highest_address), 64'(got.highest_address));
    endfunction

    // A live address to free, or zero if the table is empty.
    function logic [31:0] pick_live();
      int start;
      start = $urandom_range(63);
      for (int k = 0; k < 64; k++)
        if (slot_live[(start + k) % 64]) return slot_addr[(start + k) % 64];
      return '0;
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  bat_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  bat_pkg::out_item_t out_data;
  logic               cfg_we;
  logic               cfg_index;
  logic [31:0]        cfg_data;

  alloc_scoreboard sb;
  int cycles;
  bit calm;       // no idling on either side while set
  bit hold_req;   // asks the receiver for a long hold-off

  bump_allocator_with_tracking u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Both monitors sample pre-edge values, so drive order cannot matter.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_request(in_data);
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end
      out_ready <= calm || ($urandom_range(99) >= 33);
      @(posedge clk);
    end
  end

  // One transfer on the input channel, then maybe an idle gap.
  task automatic send(input bat_pkg::in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    if (!calm && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic req(input bat_pkg::action_t a, input logic [31:0] b,
                     input logic [31:0] n, input logic [31:0] f);
    bat_pkg::in_item_t it;
    it.action = a;
    it.byte_count = b;
    it.element_count = n;
    it.free_address = f;
    send(it);
  endtask

  // Register write once everything in flight has drained.
  task automatic write_reg(input int idx, input logic [31:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= 1'(idx);
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // Random item; mode 0 favors allocation, 1 favors free, 2 wide values.
  task automatic random_item(input int mode);
    int r;
    logic [31:0] sz;
    r = $urandom_range(99);
    sz = ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 4096);
    if (mode == 2) begin
      req(bat_pkg::action_t'($urandom_range(3)), $urandom, $urandom,
          (r < 50) ? sb.pick_live() : $urandom);
    end else if (r < ((mode == 0) ? 55 : 30)) begin
      req(bat_pkg::ACT_MALLOC, ($urandom_range(49) == 0) ? 32'd0 : sz, $urandom,
          $urandom);
    end else if (r < ((mode == 0) ? 70 : 42)) begin
      if ($urandom_range(3) == 0)
        req(bat_pkg::ACT_CALLOC, $urandom, $urandom, $urandom);
      else
        req(bat_pkg::ACT_CALLOC, $urandom_range(0, 64), $urandom_range(0, 64),
            $urandom);
    end else if (r < 92) begin
      req(bat_pkg::ACT_FREE, $urandom, $urandom, sb.pick_live());
    end else if (r < 96) begin
      req(bat_pkg::ACT_FREE, $urandom, $urandom,
          ($urandom_range(1) == 0) ? 32'd0 : $urandom);
    end else begin
      req(bat_pkg::ACT_STATS, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    calm = 0;
    hold_req = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every action, extremes and each special case.
    req(bat_pkg::ACT_STATS, '0, '0, '0);
    req(bat_pkg::ACT_MALLOC, 32'd0, '0, '0);                     // zero size
    req(bat_pkg::ACT_MALLOC, 32'd1, '0, '0);
    req(bat_pkg::ACT_MALLOC, 32'hFFFF_FFFF, '1, '1);             // no space
    req(bat_pkg::ACT_CALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);  // overflow
    req(bat_pkg::ACT_CALLOC, 32'h0001_0000, 32'h0001_0000, '0);  // overflow, wraps to zero
    req(bat_pkg::ACT_CALLOC, 32'd5, 32'd0, '0);                  // zero product
    req(bat_pkg::ACT_CALLOC, 32'd4, 32'd3, '0);
    req(bat_pkg::ACT_FREE, '0, '0, 32'd0);                       // null free
    req(bat_pkg::ACT_FREE, '0, '0, 32'hDEAD_BEEF);               // unknown free
    req(bat_pkg::ACT_FREE, '0, '0, sb.pick_live());
    req(bat_pkg::ACT_MALLOC, 32'h0080_0000, '0, '0);             // just past the end
    req(bat_pkg::ACT_MALLOC, 32'h007F_FFF3, '0, '0);             // exactly fills heap
    req(bat_pkg::ACT_MALLOC, 32'd1, '0, '0);
    req(bat_pkg::ACT_STATS, '1, '1, '1);

    // Full-size heap near the top of the address space: wrap and table full.
    write_reg(bat_pkg::CFG_HEAP_BASE, 32'hFFFF_FF00);
    write_reg(bat_pkg::CFG_HEAP_BYTES, 32'hFFFF_FFFF);
    for (int i = 0; i < 70; i++) req(bat_pkg::ACT_MALLOC, $urandom_range(1, 16), '0, '0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case (i)
        300:  write_reg(bat_pkg::CFG_HEAP_BYTES, 32'd0);
        330:  begin
          write_reg(bat_pkg::CFG_HEAP_BASE, 32'd1);
          write_reg(bat_pkg::CFG_HEAP_BYTES, 32'hFFFF_FFFF);
        end
        600:  hold_req = 1;
        700:  write_reg(bat_pkg::CFG_HEAP_BASE, bat_pkg::HEAP_BASE_RESET); // may repeat live addresses
        900:  calm = 1;
        1100: begin
          calm = 0;
          write_reg(bat_pkg::CFG_HEAP_BASE, $urandom_range(1, 32'hFFFF_FFFF));
        end
        1400: write_reg(bat_pkg::CFG_HEAP_BYTES, bat_pkg::HEAP_BYTES_RESET);
        default: ;
      endcase
      if (i >= 330 && i < 450) random_item(2);
      else random_item(((i / 150) % 2 == 0) ? 0 : 1);
    end

    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[bump_allocator_with_tracking.f]
rtl/bat_pkg.sv
rtl/bat_cell.sv
rtl/bump_allocator_with_tracking.sv
bench/testbench.sv
